### rtl/core/csr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle span rasterizer package
// Shared widths, limits and the span command passed from the walk to the
// span back end.
// ----------------------------------------------------------------------------
package csr_pkg;

    localparam int MAX_RADIUS  = 31;
    localparam int RADIUS_W    = 5;
    localparam int COORD_W     = 6;
    localparam int DEC_W       = 10;
    localparam int STORE_DEPTH = 63;
    localparam int SPAN_W      = 2 * COORD_W;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    // A command either writes one span entry or, with fin set, closes the
    // circle; then col holds the last column (twice the radius).
    typedef struct packed {
        logic               fin;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

### rtl/core/csr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data that holds
// its value between reads.
// ----------------------------------------------------------------------------
module csr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/csr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span command queue
// Short register queue between the circle walk and the span back end.
// ----------------------------------------------------------------------------
module csr_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  csr_pkg::t_cmd       i_data,
    input  logic                i_pop,
    output csr_pkg::t_cmd       o_data,
    output csr_pkg::t_fifo_stat o_stat
);
    import csr_pkg::*;

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_stat.full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/core/csr_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle walk front end
// Takes a radius, clamps it and runs the midpoint circle walk, issuing four
// span writes per octant point (three at x=0) and a closing command per circle.
// ----------------------------------------------------------------------------
module csr_walk (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [csr_pkg::RADIUS_W-1:0] i_radius,
    output logic                         o_push,
    output csr_pkg::t_cmd                o_cmd,
    input  csr_pkg::t_fifo_stat          i_stat
);
    import csr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MARK,
        S_END
    } t_state;

    t_state                    r_state;
    logic [COORD_W-1:0]        r_r;
    logic [COORD_W-1:0]        r_x;
    logic [COORD_W-1:0]        r_y;
    logic signed [DEC_W-1:0]   r_d;
    logic [1:0]                r_k;

    logic [COORD_W-1:0]        w_rad;
    logic                      w_push;
    logic                      w_pt_done;
    logic                      w_dpos;
    logic [COORD_W-1:0]        w_x1;
    logic [COORD_W-1:0]        w_y1;
    logic signed [DEC_W+1:0]   w_x1s;
    logic signed [DEC_W+1:0]   w_y1s;
    logic signed [DEC_W+1:0]   w_inc;
    logic signed [DEC_W+1:0]   w_dsum;
    logic signed [DEC_W+1:0]   w_dinit;

    always_comb begin
        w_rad = COORD_W'(i_radius);
        if (w_rad == '0) begin
            w_rad = COORD_W'(1);
        end else if (w_rad > COORD_W'(MAX_RADIUS)) begin
            w_rad = COORD_W'(MAX_RADIUS);
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign w_push  = (r_state != S_IDLE) && !i_stat.full;
    assign o_push  = w_push;

    always_comb begin
        o_cmd.fin = 1'b0;
        case (r_k)
            2'd0: begin
                o_cmd.col = r_r + r_x;
                o_cmd.lo  = r_r - r_y;
                o_cmd.hi  = r_r + r_y;
            end
            2'd1: begin
                o_cmd.col = r_r + r_y;
                o_cmd.lo  = r_r - r_x;
                o_cmd.hi  = r_r + r_x;
            end
            2'd2: begin
                o_cmd.col = r_r - r_y;
                o_cmd.lo  = r_r - r_x;
                o_cmd.hi  = r_r + r_x;
            end
            default: begin
                o_cmd.col = r_r - r_x;
                o_cmd.lo  = r_r - r_y;
                o_cmd.hi  = r_r + r_y;
            end
        endcase
        if (r_state == S_END) begin
            o_cmd.fin = 1'b1;
            o_cmd.col = COORD_W'({r_r, 1'b0});
            o_cmd.lo  = '0;
            o_cmd.hi  = '0;
        end
    end

    assign w_pt_done = (r_k == 2'd3) || ((r_k == 2'd2) && (r_x == '0));
    assign w_dpos    = (r_d > 0);
    assign w_x1      = r_x + 1'b1;
    assign w_y1      = w_dpos ? (r_y - 1'b1) : r_y;
    assign w_x1s     = $signed((DEC_W+2)'(w_x1));
    assign w_y1s     = $signed((DEC_W+2)'(w_y1));
    assign w_inc     = w_dpos ? (((w_x1s - w_y1s) <<< 2) + 12'sd10)
                              : ((w_x1s <<< 2) + 12'sd6);
    assign w_dsum    = (DEC_W+2)'(r_d) + w_inc;
    assign w_dinit   = 12'sd3 - $signed((DEC_W+2)'({w_rad, 1'b0}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_r     <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_d     <= '0;
            r_k     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_r     <= w_rad;
                        r_x     <= '0;
                        r_y     <= w_rad;
                        r_d     <= w_dinit[DEC_W-1:0];
                        r_k     <= '0;
                        r_state <= S_MARK;
                    end
                end
                S_MARK: begin
                    if (w_push) begin
                        if (w_pt_done) begin
                            r_k <= '0;
                            if (r_y >= r_x) begin
                                r_x <= w_x1;
                                r_y <= w_y1;
                                r_d <= w_dsum[DEC_W-1:0];
                            end else begin
                                r_state <= S_END;
                            end
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_END: begin
                    if (w_push) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/csr_span.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span store back end
// Applies span writes to the store and, on a closing command, reads the
// columns out in rising order through an output register.
// ----------------------------------------------------------------------------
module csr_span (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  csr_pkg::t_cmd               i_cmd,
    input  csr_pkg::t_fifo_stat         i_stat,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [csr_pkg::COORD_W-1:0] o_column,
    output logic [csr_pkg::COORD_W-1:0] o_row_min,
    output logic [csr_pkg::COORD_W-1:0] o_row_max,
    output logic                        o_last
);
    import csr_pkg::*;

    typedef enum logic {
        S_CMD,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [COORD_W-1:0] r_cur;
    logic [COORD_W-1:0] r_end_col;
    logic               r_pend;
    logic [COORD_W-1:0] r_pend_col;
    logic               r_pend_last;
    logic               r_oval;
    logic [COORD_W-1:0] r_ocol;
    logic [COORD_W-1:0] r_omin;
    logic [COORD_W-1:0] r_omax;
    logic               r_olast;

    logic               w_pop;
    logic               w_wr_en;
    logic               w_move;
    logic               w_issue;
    logic               w_cur_last;
    logic [SPAN_W-1:0]  w_rd_data;

    assign w_pop      = (r_state == S_CMD) && !i_stat.empty;
    assign o_pop      = w_pop;
    assign w_wr_en    = w_pop && !i_cmd.fin && (i_cmd.col < COORD_W'(STORE_DEPTH));
    assign w_move     = r_pend && (!r_oval || i_ready);
    assign w_issue    = (r_state == S_EMIT) && (!r_pend || w_move);
    assign w_cur_last = (r_cur == r_end_col);

    csr_ram #(
        .WIDTH (SPAN_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (i_cmd.col),
        .i_wr_data ({i_cmd.hi, i_cmd.lo}),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_cur),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CMD;
            r_cur       <= '0;
            r_end_col   <= '0;
            r_pend      <= 1'b0;
            r_pend_col  <= '0;
            r_pend_last <= 1'b0;
            r_oval      <= 1'b0;
            r_ocol      <= '0;
            r_omin      <= '0;
            r_omax      <= '0;
            r_olast     <= 1'b0;
        end else begin
            case (r_state)
                S_CMD: begin
                    if (w_pop && i_cmd.fin) begin
                        r_end_col <= i_cmd.col;
                        r_cur     <= '0;
                        r_state   <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_issue) begin
                        r_cur <= r_cur + 1'b1;
                        if (w_cur_last) begin
                            r_state <= S_CMD;
                        end
                    end
                end
                default: begin
                    r_state <= S_CMD;
                end
            endcase

            if (w_issue) begin
                r_pend      <= 1'b1;
                r_pend_col  <= r_cur;
                r_pend_last <= w_cur_last;
            end else if (w_move) begin
                r_pend <= 1'b0;
            end

            if (w_move) begin
                r_oval  <= 1'b1;
                r_ocol  <= r_pend_col;
                r_omin  <= w_rd_data[COORD_W-1:0];
                r_omax  <= w_rd_data[SPAN_W-1:COORD_W];
                r_olast <= r_pend_last;
            end else if (i_ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    assign o_valid   = r_oval;
    assign o_column  = r_ocol;
    assign o_row_min = r_omin;
    assign o_row_max = r_omax;
    assign o_last    = r_olast;

endmodule

### rtl/core/circle_span_rasterizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle span rasterizer
// Midpoint circle walk that fills a column span store and streams out one
// lowest/highest row pair per bounding-box column.
// ----------------------------------------------------------------------------
// The walk issues four commands per octant point (three for the first point)
// and then one closing command. That command passes through the queue, and
// the first beat through the store read register and the output register.
// Throughput: 2r+1 beats at one per cycle while the receiver is ready, set
// by the single store read port. The next radius is accepted once the closing
// command is queued, but its walk stalls after four commands until the
// previous circle is read out. Reset clears all control state; the span
// store is not cleared, as every column is written before it is read.
module circle_span_rasterizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [4:0] radius
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [5:0] column, [11:6] row_min, [17:12] row_max
    output logic        m_axis_tlast
);
    import csr_pkg::*;

    logic               w_push;
    logic               w_pop;
    t_cmd               w_cmd_in;
    t_cmd               w_cmd_out;
    t_fifo_stat         w_stat;
    logic [COORD_W-1:0] w_column;
    logic [COORD_W-1:0] w_row_min;
    logic [COORD_W-1:0] w_row_max;

    csr_walk u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_radius (s_axis_tdata[RADIUS_W-1:0]),
        .o_push   (w_push),
        .o_cmd    (w_cmd_in),
        .i_stat   (w_stat)
    );

    csr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .i_pop   (w_pop),
        .o_data  (w_cmd_out),
        .o_stat  (w_stat)
    );

    csr_span u_span (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd_out),
        .i_stat    (w_stat),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_column  (w_column),
        .o_row_min (w_row_min),
        .o_row_max (w_row_max),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b0, w_row_max, w_row_min, w_column};

endmodule

### sim/tb_circle_span_rasterizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle span rasterizer testbench
// Streams radius beats into the rasterizer and checks every column span
// against an independent midpoint circle walk. Three traffic phases are run:
// a slow sender with a slower receiver, the reverse, then full rate.
// ----------------------------------------------------------------------------
module tb_circle_span_rasterizer_unit;

    import csr_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 10;
    localparam int RAND_ITEMS  = 35;
    localparam int TAIL_CYC    = 300;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        bit [COORD_W-1:0] column;
        bit [COORD_W-1:0] row_min;
        bit [COORD_W-1:0] row_max;
        bit               last;
    } t_span_beat;

    class t_span_scoreboard;
        bit [COORD_W-1:0]      low_rows [STORE_DEPTH];
        bit [COORD_W-1:0]      high_rows[STORE_DEPTH];
        bit [COORD_W-1:0]      walk_x;
        bit [COORD_W-1:0]      walk_y;
        bit signed [DEC_W-1:0] decision;
        bit [COORD_W-1:0]      emit_cursor;
        t_span_beat            span_q[$];
        int                    errors;
        int                    radii_seen;
        int                    beats_seen;

        function void put_span(int col, int lo, int hi);
            if (col < 0 || col >= STORE_DEPTH) begin
                return;
            end
            low_rows[col]  = lo[COORD_W-1:0];
            high_rows[col] = hi[COORD_W-1:0];
        endfunction

        function void mark_octants(int r, int x, int y);
            put_span(r + x, r - y, r + y);
            put_span(r + y, r - x, r + x);
            put_span(r - y, r - x, r + x);
            if (x != 0) begin
                put_span(r - x, r - y, r + y);
            end
        endfunction

        // Walks one octant, fills the span stores and queues one beat per column.
        function void note_radius(bit [RADIUS_W-1:0] radius_in);
            int         r;
            int         x;
            int         y;
            int         d;
            t_span_beat beat;
            r = radius_in;
            if (r < 1) begin
                r = 1;
            end
            if (r > MAX_RADIUS) begin
                r = MAX_RADIUS;
            end
            x = 0;
            y = r;
            d = 3 - 2 * r;
            mark_octants(r, x, y);
            while (y >= x) begin
                x++;
                if (d > 0) begin
                    y--;
                    d = d + 4 * (x - y) + 10;
                end else begin
                    d = d + 4 * x + 6;
                end
                mark_octants(r, x, y);
            end
            walk_x   = x[COORD_W-1:0];
            walk_y   = y[COORD_W-1:0];
            decision = d[DEC_W-1:0];
            for (int c = 0; c <= 2 * r; c++) begin
                beat.column  = c[COORD_W-1:0];
                beat.row_min = low_rows[c];
                beat.row_max = high_rows[c];
                beat.last    = (c == 2 * r);
                span_q.push_back(beat);
            end
            emit_cursor = COORD_W'(2 * r + 1);
            radii_seen++;
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_span(bit [COORD_W-1:0] column, bit [COORD_W-1:0] row_min,
                        bit [COORD_W-1:0] row_max, bit last);
            t_span_beat want;
            beats_seen++;
            if (span_q.size() == 0) begin
                report($sformatf("unexpected beat column=%0d", column));
                return;
            end
            want = span_q.pop_front();
            if (column != want.column) begin
                report($sformatf("column got %0d want %0d", column, want.column));
            end
            if (row_min != want.row_min) begin
                report($sformatf("row_min col %0d got %0d want %0d",
                                 want.column, row_min, want.row_min));
            end
            if (row_max != want.row_max) begin
                report($sformatf("row_max col %0d got %0d want %0d",
                                 want.column, row_max, want.row_max));
            end
            if (last != want.last) begin
                report($sformatf("tlast col %0d got %0d want %0d",
                                 want.column, last, want.last));
            end
        endtask
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [4:0] radius
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [5:0] column, [11:6] row_min, [17:12] row_max
    logic        m_axis_tlast;

    t_span_scoreboard sb = new;
    int               tx_idle_pct;
    int               rx_idle_pct;
    int               cycle_count;

    circle_span_rasterizer_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_span(m_axis_tdata[5:0], m_axis_tdata[11:6],
                          m_axis_tdata[17:12], m_axis_tlast);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats still due",
                     cycle_count, sb.span_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task send_radius(bit [RADIUS_W-1:0] radius);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, radius};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        sb.note_radius(radius);
    endtask

    task send_random_radii(int count);
        for (int n = 0; n < count; n++) begin
            send_radius(RADIUS_W'($urandom_range(0, MAX_RADIUS)));
        end
    endtask

    task drain_spans();
        s_axis_tvalid <= 1'b0;
        while (sb.span_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        bit [RADIUS_W-1:0] directed[$];
        directed = {5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd31, 5'd30, 5'd7,
                    5'd8, 5'd10, 5'd21, 5'd15, 5'd16, 5'd0, 5'd31, 5'd1};
        tx_idle_pct = 37;
        rx_idle_pct = 64;
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            send_radius(directed[i]);
        end
        send_random_radii(RAND_ITEMS);
        drain_spans();

        tx_idle_pct = 64;
        rx_idle_pct = 37;
        send_random_radii(RAND_ITEMS);
        drain_spans();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random_radii(RAND_ITEMS);
        drain_spans();

        repeat (TAIL_CYC) @(posedge i_clk);

        $display("Sent %0d radii over three traffic phases and checked %0d span beats.",
                 sb.radii_seen, sb.beats_seen);
        $display("Mismatches: %0d, spans still due: %0d", sb.errors, sb.span_q.size());
        if (sb.errors == 0 && sb.span_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
